/* rtl/pns_pkg.sv */
// Shared types, codes and constants for the 2-D gradient noise octave-sum core.
package pns_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic CFG_SCALE  = 1'b0;
    localparam logic CFG_OCTAVE = 1'b1;

    localparam logic [15:0] SCALE_RESET  = 16'd3277;
    localparam logic [3:0]  OCTAVE_RESET = 4'd4;

    localparam logic [31:0] GRAD_X_FLAGS = 32'h4655_2222;
    localparam logic [31:0] GRAD_Y_FLAGS = 32'h2222_550A;

    localparam logic signed [25:0] OUT_MAX = 26'sh1FF_FFFF;
    localparam logic signed [25:0] OUT_MIN = -26'sh200_0000;

    // One queued word: scaled positions are Q8.16, only the low 24 bits matter
    typedef struct packed {
        logic        op;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [23:0] px;
        logic [23:0] py;
    } pns_item_t;

endpackage

/* rtl/perlin_noise_2d_octave_sum_core.sv */
// Top level of the 2-D gradient noise core with octave-sum weighting.
//
//  channel   dir  tdata (low bit up)                             tuser
//  s_axis    in   table_index 8, table_value 8, coord_x 16,      op
//                 coord_y 16
//  m_axis    out  noise_sum 26, zero pad 6                       -
//  cfg       in   cfg_addr 0 = scale_recip, 1 = octave_count     -
//
// One word per cycle sustained for evaluations while m_axis is ready; a result is offered
// on m_axis once its word has passed the front register, the queue write and seven back
// stages, and the output register has loaded it.
// A load waits in the queue while an evaluation ahead of it is still in its
// two table-read stages, so a load right after an evaluation holds up the queue.
// Reset clears all control state; the permutation table is not cleared.
// The whole back end stalls on the output register; the queue absorbs the front.
module perlin_noise_2d_octave_sum_core
#(
    parameter int FRAC_BITS   = pns_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // table_index, table_value, coord_x, coord_y
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // noise_sum, zero pad
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    logic [15:0] scale_reg;
    logic [3:0]  octave_reg;
    logic        push, pop, head_valid;
    logic [2:0]  q_count;
    logic [25:0] noise;
    pns_pkg::pns_item_t push_item, head_item;

    // the table is always 256 deep (pns_pkg::TABLE_DEPTH_DEF); the hash indexes are 8 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= pns_pkg::SCALE_RESET;
            octave_reg <= pns_pkg::OCTAVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                pns_pkg::CFG_SCALE:  scale_reg  <= cfg_wdata;
                pns_pkg::CFG_OCTAVE: octave_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    pns_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_data     (s_axis_tdata),
        .scale_recip (scale_reg),
        .q_count     (q_count),
        .push        (push),
        .push_item   (push_item)
    );

    pns_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    pns_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .octave_count (octave_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_value    (noise)
    );

    assign m_axis_tdata = {6'b0, noise};
endmodule

/* rtl/pns_front.sv */
// Front end: takes input words, scales coordinates, pushes into the queue.
module pns_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  logic [47:0]       in_data,
    input  logic [15:0]       scale_recip,
    input  logic [2:0]        q_count,
    output logic              push,
    output pns_pkg::pns_item_t push_item
);
    logic               f_valid_reg;
    pns_pkg::pns_item_t f_item_reg;
    logic signed [32:0] prod_x;
    logic signed [32:0] prod_y;
    logic               accept;

    // room for the word already held plus a new one
    assign in_ready = ({1'b0, q_count} + {3'b0, f_valid_reg})
                      < 4'(pns_pkg::QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    assign prod_x = $signed(in_data[31:16]) * $signed({1'b0, scale_recip});
    assign prod_y = $signed(in_data[47:32]) * $signed({1'b0, scale_recip});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg.op  <= in_op;
            f_item_reg.idx <= in_data[7:0];
            f_item_reg.val <= in_data[15:8];
            f_item_reg.px  <= prod_x[23:0];
            f_item_reg.py  <= prod_y[23:0];
        end
    end

    assign push      = f_valid_reg;
    assign push_item = f_item_reg;
endmodule

/* rtl/pns_queue.sv */
// Short FIFO between front and back ends.
module pns_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pns_pkg::pns_item_t push_item,
    input  logic               pop,
    output logic               head_valid,
    output pns_pkg::pns_item_t head_item,
    output logic [2:0]         count
);
    pns_pkg::pns_item_t entry_reg [pns_pkg::QUEUE_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign head_valid = count_reg != 3'd0;
    assign head_item  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
endmodule

/* rtl/pns_back.sv */
// Back end: table lookups, fade, gradients, interpolation, weighting, output register.
module pns_back
#(
    parameter int FRAC_BITS = pns_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  pns_pkg::pns_item_t head_item,
    output logic               pop,
    input  logic [3:0]         octave_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [25:0]        out_value
);
    localparam int F  = FRAC_BITS;
    localparam int AW = F + 5;            // 6t - 15
    localparam int GW = F + 6;            // corner gradient
    localparam int DW = GW + 1;
    localparam int PW = DW + F + 2;
    localparam int CW = PW - F;           // lerp result
    localparam int NW = CW + 17;          // weighted noise
    localparam int EW = NW + 17;
    localparam int SR = (F >= 16) ? F - 16 : 0;
    localparam int SL = (F < 16) ? 16 - F : 0;
    localparam logic signed [AW-1:0] FIFTEEN = AW'(15 <<< F);
    localparam logic signed [AW:0]   TEN     = (AW + 1)'(10 <<< F);
    localparam logic signed [F+1:0]  ONE     = (F + 2)'(1 <<< F);

    // five copies of the permutation table, two read ports each
    logic [7:0] perm0 [256];
    logic [7:0] perm1 [256];
    logic [7:0] perm2 [256];
    logic [7:0] perm3 [256];
    logic [7:0] perm4 [256];

    logic en;
    logic dispatch;
    logic load_wr;
    logic [6:0] v_reg;
    logic       o_valid_reg;
    logic [25:0] o_data_reg;

    // dispatch fields
    logic [39:0]  fwx, fwy;
    logic [7:0]   xi, yi;
    logic [F-1:0] xf, yf;
    logic signed [AW-1:0] ax, ay;

    // stage 1
    logic [7:0]   r0a_reg, r0b_reg, yi1_reg;
    logic [F-1:0] xf1_reg, yf1_reg;
    logic signed [2*AW-1:0] tax1_reg, tay1_reg;
    logic [2*F-1:0] ttx1_reg, tty1_reg;
    // stage 2
    logic [7:0]   r1a_reg, r1b_reg, r2a_reg, r2b_reg;
    logic [F-1:0] xf2_reg, yf2_reg;
    logic signed [AW:0] bx2_reg, by2_reg;
    logic [2*F-1:0] t3x2_reg, t3y2_reg;
    logic [7:0]   ha, hb, ha1, hb1;
    // stage 3
    logic [7:0]   h0_reg, h1_reg, h2_reg, h3_reg;
    logic [F-1:0] xf3_reg, yf3_reg;
    logic signed [2*F+6:0] fpx3_reg, fpy3_reg;
    // stage 4
    logic signed [F+1:0] u4_reg, v4_reg;
    logic signed [GW-1:0] g0_reg, g1_reg, g2_reg, g3_reg;
    // stage 5
    logic signed [F+1:0] v5_reg;
    logic signed [GW-1:0] g0_5_reg, g2_5_reg;
    logic signed [PW-1:0] pa5_reg, pb5_reg;
    // stage 6
    logic signed [CW-1:0] c1, c2, c1_6_reg;
    logic signed [CW+F+2:0] pc6_reg;
    // stage 7
    logic signed [CW-1:0] n7;
    logic signed [NW-1:0] nw7_reg;
    logic [15:0] weight;
    logic signed [EW-1:0] ext, shifted;
    logic signed [F+1:0] dx0, dx1, dy0, dy1;

    function automatic logic signed [GW-1:0] corner(input logic [7:0] h,
                                                     input logic signed [F+1:0] dx,
                                                     input logic signed [F+1:0] dy);
        logic [1:0] sx, sy;
        logic signed [2:0] gx, gy;
        logic signed [GW-1:0] ex, ey;
        sx = pns_pkg::GRAD_X_FLAGS[{h[3:0], 1'b0} +: 2];
        sy = pns_pkg::GRAD_Y_FLAGS[{h[3:0], 1'b0} +: 2];
        gx = $signed({1'b0, sx}) - 3'sd1;
        gy = $signed({1'b0, sy}) - 3'sd1;
        ex = GW'(dx);
        ey = GW'(dy);
        return GW'(gx * ex) + GW'(gy * ey);
    endfunction

    assign en       = !o_valid_reg || out_ready;
    // a load waits until no evaluation still has table reads pending
    assign dispatch = en && head_valid &&
                      (head_item.op == pns_pkg::OP_EVAL || !(v_reg[0] || v_reg[1]));
    assign load_wr  = dispatch && head_item.op == pns_pkg::OP_LOAD;
    assign pop      = dispatch;

    assign fwx = {head_item.px[15:0], 24'b0};
    assign fwy = {head_item.py[15:0], 24'b0};
    assign xi  = head_item.px[23:16];
    assign yi  = head_item.py[23:16];
    assign xf  = fwx[39 -: F];
    assign yf  = fwy[39 -: F];
    assign ax  = AW'($signed({5'b0, xf}) * 6) - FIFTEEN;
    assign ay  = AW'($signed({5'b0, yf}) * 6) - FIFTEEN;

    assign ha  = r0a_reg + yi1_reg;
    assign hb  = r0b_reg + yi1_reg;
    assign ha1 = ha + 8'd1;
    assign hb1 = hb + 8'd1;

    assign dx0 = $signed({2'b0, xf3_reg});
    assign dy0 = $signed({2'b0, yf3_reg});
    assign dx1 = dx0 - ONE;
    assign dy1 = dy0 - ONE;

    assign c1 = CW'(g0_5_reg) + CW'(pa5_reg >>> F);
    assign c2 = CW'(g2_5_reg) + CW'(pb5_reg >>> F);
    assign n7 = c1_6_reg + CW'(pc6_reg >>> F);
    assign weight = 16'((17'd1 << octave_count) - 17'd1);

    assign ext     = EW'(nw7_reg);
    assign shifted = (ext <<< SL) >>> SR;

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            perm0[head_item.idx] <= head_item.val;
            perm1[head_item.idx] <= head_item.val;
            perm2[head_item.idx] <= head_item.val;
            perm3[head_item.idx] <= head_item.val;
            perm4[head_item.idx] <= head_item.val;
        end
        if (en)
        begin
            r0a_reg <= perm0[xi];
            r0b_reg <= perm0[xi + 8'd1];
            r1a_reg <= perm1[ha];
            r1b_reg <= perm1[hb];
            r2a_reg <= perm2[ha1];
            r2b_reg <= perm2[hb1];
            h0_reg  <= perm3[r1a_reg];
            h1_reg  <= perm3[r1b_reg];
            h2_reg  <= perm4[r2a_reg];
            h3_reg  <= perm4[r2b_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yi1_reg  <= yi;
            xf1_reg  <= xf;
            yf1_reg  <= yf;
            tax1_reg <= $signed({5'b0, xf}) * ax;
            tay1_reg <= $signed({5'b0, yf}) * ay;
            ttx1_reg <= xf * xf;
            tty1_reg <= yf * yf;

            xf2_reg  <= xf1_reg;
            yf2_reg  <= yf1_reg;
            bx2_reg  <= (AW + 1)'(tax1_reg >>> F) + TEN;
            by2_reg  <= (AW + 1)'(tay1_reg >>> F) + TEN;
            t3x2_reg <= ttx1_reg[2*F-1:F] * xf1_reg;
            t3y2_reg <= tty1_reg[2*F-1:F] * yf1_reg;

            xf3_reg  <= xf2_reg;
            yf3_reg  <= yf2_reg;
            fpx3_reg <= $signed({1'b0, t3x2_reg[2*F-1:F]}) * bx2_reg;
            fpy3_reg <= $signed({1'b0, t3y2_reg[2*F-1:F]}) * by2_reg;

            u4_reg <= fpx3_reg[2*F+1:F];
            v4_reg <= fpy3_reg[2*F+1:F];
            g0_reg <= corner(h0_reg, dx0, dy0);
            g1_reg <= corner(h1_reg, dx1, dy0);
            g2_reg <= corner(h2_reg, dx0, dy1);
            g3_reg <= corner(h3_reg, dx1, dy1);

            v5_reg   <= v4_reg;
            g0_5_reg <= g0_reg;
            g2_5_reg <= g2_reg;
            pa5_reg  <= u4_reg * (DW'(g1_reg) - DW'(g0_reg));
            pb5_reg  <= u4_reg * (DW'(g3_reg) - DW'(g2_reg));

            c1_6_reg <= c1;
            pc6_reg  <= v5_reg * ((CW + 1)'(c2) - (CW + 1)'(c1));

            nw7_reg  <= NW'(n7 * $signed({1'b0, weight}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg       <= {v_reg[5:0], dispatch && head_item.op == pns_pkg::OP_EVAL};
                o_valid_reg <= v_reg[6];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v_reg[6])
        begin
            if (shifted > EW'(pns_pkg::OUT_MAX))
                o_data_reg <= pns_pkg::OUT_MAX;
            else if (shifted < EW'(pns_pkg::OUT_MIN))
                o_data_reg <= pns_pkg::OUT_MIN;
            else
                o_data_reg <= shifted[25:0];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_value = o_data_reg;

    a_load_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        load_wr |-> !(v_reg[0] || v_reg[1]))
        else $error("table written while an evaluation still reads it");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during a stall");
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && en)
        else $error("pop from empty queue or while stalled");
endmodule

/* bench/noise_sum_checker.sv */
// Stream checker for the noise core: predicts each noise_sum word and compares.
module noise_sum_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 64'sd65536;

    logic [7:0]        perm_tab [256];
    logic [15:0]       scale_q;
    logic [3:0]        octaves;
    logic [25:0]       noise_due [$];

    function automatic longint ease_q(input longint t);
        longint a, b, t2, t3;
        a  = 6 * t - 15 * ONE;
        b  = ((t * a) >>> 16) + 10 * ONE;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        return (t3 * b) >>> 16;
    endfunction

    function automatic longint grad_dot(input logic [7:0] h, input longint dx, input longint dy);
        int     s;
        longint gx, gy;
        s  = int'(h[3:0]) * 2;
        gx = longint'(2'(pns_pkg::GRAD_X_FLAGS >> s)) - 1;
        gy = longint'(2'(pns_pkg::GRAD_Y_FLAGS >> s)) - 1;
        return gx * dx + gy * dy;
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint w);
        return a + ((w * (b - a)) >>> 16);
    endfunction

    function automatic logic [7:0] hash2(input int i);
        return perm_tab[perm_tab[i & 255]];
    endfunction

    function automatic logic [25:0] noise_at(input logic [15:0] x, input logic [15:0] y);
        longint px, py, xf, yf, u, v, c1, c2, n;
        int     xi, yi, ha, hb;
        px = longint'($signed(x)) * longint'(scale_q);
        py = longint'($signed(y)) * longint'(scale_q);
        xi = int'((px >>> 16) & 255);
        yi = int'((py >>> 16) & 255);
        xf = px & 16'hFFFF;
        yf = py & 16'hFFFF;
        u  = ease_q(xf);
        v  = ease_q(yf);
        ha = int'(perm_tab[xi]) + yi;
        hb = int'(perm_tab[(xi + 1) & 255]) + yi;
        c1 = mix(grad_dot(hash2(ha), xf, yf), grad_dot(hash2(hb), xf - ONE, yf), u);
        c2 = mix(grad_dot(hash2(ha + 1), xf, yf - ONE),
                 grad_dot(hash2(hb + 1), xf - ONE, yf - ONE), u);
        n  = mix(c1, c2, v) * ((64'sd1 << octaves) - 1);
        if (n > longint'(pns_pkg::OUT_MAX))
            n = longint'(pns_pkg::OUT_MAX);
        if (n < longint'(pns_pkg::OUT_MIN))
            n = longint'(pns_pkg::OUT_MIN);
        return n[25:0];
    endfunction

    assign pending = noise_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [25:0] due;
        if (!rst_n)
        begin
            scale_q <= pns_pkg::SCALE_RESET;
            octaves <= pns_pkg::OCTAVE_RESET;
            errors  <= 0;
            noise_due.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_addr == pns_pkg::CFG_SCALE)
                    scale_q <= cfg_wdata;
                else
                    octaves <= cfg_wdata[3:0];
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == pns_pkg::OP_EVAL)
                    noise_due.push_back(noise_at(s_tdata[31:16], s_tdata[47:32]));
                else
                    perm_tab[s_tdata[7:0]] = s_tdata[15:8];
            end
            if (m_tvalid && m_tready)
            begin
                if (noise_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("noise word %h with nothing expected", m_tdata[25:0]);
                    errors <= errors + 1;
                end
                else
                begin
                    due = noise_due.pop_front();
                    if (due !== m_tdata[25:0])
                    begin
                        if (errors < 10)
                            $display("noise_sum mismatch: expected %h got %h",
                                     due, m_tdata[25:0]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* bench/tb.sv */
// Testbench top: clock, reset, stimulus and verdict for the noise core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT  = 500000;   // generous cycle budget
    localparam int SETTLE = 16;       // settling margin beyond the pipeline latency

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // table_index, table_value, coord_x, coord_y
    logic        s_axis_tuser = pns_pkg::OP_LOAD; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // noise_sum, zero pad
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = pns_pkg::CFG_SCALE;
    logic [15:0] cfg_wdata = '0;
    int          pending;
    int          errors;
    int          cycles = 0;
    int          burst_left = 0;

    always #6 clk = ~clk;

    perlin_noise_2d_octave_sum_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    noise_sum_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .pending(pending), .errors(errors)
    );

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure: modes switch every so often, including always-ready stretches
    always @(posedge clk)
    begin
        int mode, span;
        if (span == 0)
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 256);
        end
        span = span - 1;
        case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (span % 8) < 2;
        endcase
    end

    // Present one word and hold it until taken. tready is sampled at the
    // falling edge, where it is settled; the word goes at the next rising edge.
    task automatic send_word(input logic op, input logic [7:0] idx, input logic [7:0] val,
                             input logic [15:0] x, input logic [15:0] y);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y, x, val, idx};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    // Burst pacing for the sender: random bursts, random gaps, some unbroken runs
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Stop sending and wait until every noise word has come back, plus SETTLE as margin
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] scale, input logic [3:0] oct);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= pns_pkg::CFG_SCALE;
        cfg_wdata <= scale;
        @(posedge clk);
        cfg_addr  <= pns_pkg::CFG_OCTAVE;
        cfg_wdata <= {12'd0, oct};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly evaluations with random coordinates, some table rewrites; the
    // table is full throughout so no read ever hits an unwritten entry.
    task automatic random_words(input int count);
        logic [15:0] x, y;
        repeat (count)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            if ($urandom_range(0, 15) == 0)
                x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 2) == 0)
                send_word(pns_pkg::OP_LOAD, 8'($urandom), 8'($urandom), x, y);
            else
                send_word(pns_pkg::OP_EVAL, 8'($urandom), 8'($urandom), x, y);
            pace();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole permutation table before any evaluation
        for (int i = 0; i < 256; i++)
            send_word(pns_pkg::OP_LOAD, i[7:0], 8'($urandom), 16'($urandom), 16'($urandom));

        // Directed: coordinate extremes, extreme table entries, both ops
        send_word(pns_pkg::OP_EVAL, 8'hFF, 8'hFF, 16'h0000, 16'h0000);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'h7FFF, 16'h7FFF);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'h8000, 16'h8000);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'h7FFF, 16'h8000);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'hFFFF, 16'h0001);
        send_word(pns_pkg::OP_LOAD, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_word(pns_pkg::OP_LOAD, 8'hFF, 8'h00, 16'h0000, 16'h0000);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'd20, 16'hFFEC);
        send_word(pns_pkg::OP_LOAD, 8'h12, 8'h34, 16'h0, 16'h0);
        send_word(pns_pkg::OP_EVAL, 8'h00, 8'h00, 16'd19, 16'd21);
        random_words(300);
        drain();   // sender holds off until every result is in

        // Register settings, extremes included: full scale and weight, zero
        // weight, zero scale, the smallest of each, a random one, then 40000 and 9
        set_regs(16'hFFFF, 4'hF);
        random_words(300);
        drain();
        set_regs(16'h0001, 4'h0);
        random_words(150);
        drain();
        set_regs(16'h0000, 4'h8);
        random_words(100);
        drain();
        set_regs(16'h0001, 4'h1);
        random_words(300);
        drain();
        set_regs(16'($urandom), 4'($urandom_range(1, 8)));
        random_words(200);
        drain();
        set_regs(16'd40000, 4'h9);
        random_words(300);
        drain();

        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
